FILE: src/fvt_pkg.sv
// ----------------------------------------------------------------------------
// fvt_pkg
// Shared types, constants and helpers for the frustum visibility test.
// ----------------------------------------------------------------------------
package fvt_pkg;

    localparam int NUM_PLANES  = 6;
    localparam int COORD_WIDTH = 16;
    localparam int PLANE_REGS  = 6;
    localparam int FIELD_W     = 16;
    localparam int NORM_W      = 16;
    localparam int RAD_W       = 15;
    localparam int FRAC_BITS   = 14;
    localparam int PLANE_W     = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int PROD_W      = COORD_WIDTH + NORM_W;
    localparam int DIST_W      = ((PROD_W > NORM_W + FRAC_BITS) ? PROD_W
                                                                : NORM_W + FRAC_BITS) + 3;

    typedef enum logic [1:0] {
        CMD_POINT  = 2'd0,
        CMD_BOX    = 2'd1,
        CMD_SPHERE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [NORM_W-1:0]      norm_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [DIST_W-1:0]      dist_t;
    typedef logic [PLANE_W-1:0]            plane_t;

    typedef struct packed {
        cmd_t             cmd;
        coord_t           lo_x;
        coord_t           lo_y;
        coord_t           lo_z;
        coord_t           hi_x;
        coord_t           hi_y;
        coord_t           hi_z;
        logic [RAD_W-1:0] radius;
    } item_t;

    // handshake between two pipeline stages
    typedef struct packed {
        logic valid;
        logic ready;
    } pipe_hs_t;

    // k = 0..2 normal x,y,z; k = 3 distance
    function automatic norm_t plane_part(input plane_t p, input logic [1:0] k);
        return norm_t'(p[{k, 4'b0000} +: NORM_W]);
    endfunction

endpackage

FILE: src/fvt_plane_regs.sv
// ----------------------------------------------------------------------------
// fvt_plane_regs
// Plane register file written through the configuration channel.
// ----------------------------------------------------------------------------
module fvt_plane_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fvt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fvt_pkg::PLANE_W-1:0]    cfg_data,
    output fvt_pkg::plane_t                planes [fvt_pkg::NUM_PLANES]
);
    import fvt_pkg::*;

    plane_t planes_reg  [NUM_PLANES];
    plane_t planes_next [NUM_PLANES];

    assign cfg_ready = 1'b1;

    always_comb begin
        for (int i = 0; i < NUM_PLANES; i++) begin
            planes_next[i] = planes_reg[i];
            // planes without a register stay zero
            if (cfg_valid && (cfg_index == CFG_IDX_W'(i)) && (i < PLANE_REGS)) begin
                planes_next[i] = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_PLANES; i++) begin
            if (!aresetn) begin
                planes_reg[i] <= '0;
            end else begin
                planes_reg[i] <= planes_next[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_PLANES; i++) begin
            planes[i] = planes_reg[i];
        end
    end

endmodule

FILE: src/fvt_dot_stage.sv
// ----------------------------------------------------------------------------
// fvt_dot_stage
// Corner selection and normal-by-coordinate products for every plane.
// ----------------------------------------------------------------------------
module fvt_dot_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  fvt_pkg::item_t              item,
    input  fvt_pkg::plane_t             planes   [fvt_pkg::NUM_PLANES],
    output fvt_pkg::pipe_hs_t           out_hs_fwd,
    input  logic                        out_ready,
    output fvt_pkg::prod_t              prod     [fvt_pkg::NUM_PLANES][3],
    output fvt_pkg::cmd_t               cmd,
    output logic [fvt_pkg::RAD_W-1:0]   radius
);
    import fvt_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    prod_t            prod_reg   [NUM_PLANES][3];
    prod_t            prod_next  [NUM_PLANES][3];
    cmd_t             cmd_reg;
    logic [RAD_W-1:0] radius_reg;
    coord_t           lo [3];
    coord_t           hi [3];

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        lo[0] = item.lo_x;
        lo[1] = item.lo_y;
        lo[2] = item.lo_z;
        hi[0] = item.hi_x;
        hi[1] = item.hi_y;
        hi[2] = item.hi_z;
    end

    always_comb begin
        norm_t  n;
        coord_t v;
        for (int i = 0; i < NUM_PLANES; i++) begin
            for (int a = 0; a < 3; a++) begin
                n = plane_part(planes[i], 2'(a));
                // box takes the max corner only where the normal is positive
                if ((item.cmd == CMD_BOX) && !n[NORM_W-1] && (n != '0)) begin
                    v = hi[a];
                end else begin
                    v = lo[a];
                end
                prod_next[i][a] = PROD_W'(n) * PROD_W'(v);
            end
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prod_reg   <= prod_next;
            cmd_reg    <= item.cmd;
            radius_reg <= item.radius;
        end
    end

    assign out_hs_fwd.valid = valid_reg;
    assign out_hs_fwd.ready = in_ready;
    assign prod   = prod_reg;
    assign cmd    = cmd_reg;
    assign radius = radius_reg;

endmodule

FILE: src/fvt_decide.sv
// ----------------------------------------------------------------------------
// fvt_decide
// Per-plane distance sums, the pass test of each primitive kind, result reg.
// ----------------------------------------------------------------------------
module fvt_decide (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  fvt_pkg::prod_t              prod     [fvt_pkg::NUM_PLANES][3],
    input  fvt_pkg::cmd_t               cmd,
    input  logic [fvt_pkg::RAD_W-1:0]   radius,
    input  fvt_pkg::plane_t             planes   [fvt_pkg::NUM_PLANES],
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        inside_res
);
    import fvt_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic                  inside_reg;
    logic                  inside_next;
    logic [NUM_PLANES-1:0] fail;
    dist_t                 rad_q;

    assign in_ready = !valid_reg || out_ready;
    assign rad_q    = dist_t'(DIST_W'(radius) << FRAC_BITS);

    always_comb begin
        dist_t dist_sum;
        dist_t sph;
        for (int i = 0; i < NUM_PLANES; i++) begin
            dist_sum = DIST_W'(prod[i][0]) + DIST_W'(prod[i][1]) + DIST_W'(prod[i][2])
                     + (DIST_W'(plane_part(planes[i], 2'd3)) <<< FRAC_BITS);
            sph      = dist_sum + rad_q;
            case (cmd)
                CMD_POINT:  fail[i] = (dist_sum <= 0);
                CMD_BOX:    fail[i] = (dist_sum < 0);
                CMD_SPHERE: fail[i] = (sph <= 0);
                default:    fail[i] = 1'b1;
            endcase
        end
    end

    assign inside_next = ~|fail;
    assign valid_next  = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            inside_reg <= inside_next;
        end
    end

    assign out_valid  = valid_reg;
    assign inside_res = inside_reg;

endmodule

FILE: src/frustum_visibility_test.sv
// ----------------------------------------------------------------------------
// frustum_visibility_test
// Tests a point, box or sphere against six frustum planes.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: one beat writes a 64-bit plane (nx, ny, nz Q1.14 and d,
//   16 bits each, lowest first) to the plane register picked by cfg_index;
//   indexes past the last plane are dropped. cfg_ready is always high.
//   Write planes only while no primitive is in flight.
//   s_ channel: one primitive per beat, kind in tuser, coordinates in tdata.
//   m_ channel: one beat per primitive, bit 0 of tdata set when the
//   primitive lies inside every plane. Results leave in input order.
//   The input register loads on the beat, then the product register (one
//   16x16 multiply per plane and axis), then the result register after the
//   per-plane sum and compare; the result register drives m_tvalid.
//   Throughput is one primitive per cycle while m_tready stays high. Each
//   stage holds its beat while the one behind it is full, so a stalled
//   receiver fills the three stages before s_tready drops; bubbles close
//   up as the receiver resumes.
//   Reset clears the planes to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module frustum_visibility_test (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fvt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fvt_pkg::PLANE_W-1:0]   cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, radius, zero pad
    input  logic [111:0]                  s_tdata,
    // cmd
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // inside_res, zero pad
    output logic [7:0]                    m_tdata
);
    import fvt_pkg::*;

    plane_t           planes [NUM_PLANES];
    item_t            item_reg;
    item_t            item_next;
    logic             valid_reg;
    logic             valid_next;
    logic             in_ready;
    pipe_hs_t         dot_hs;
    logic             dot_in_ready;
    logic             dec_in_ready;
    prod_t            prod [NUM_PLANES][3];
    cmd_t             dot_cmd;
    logic [RAD_W-1:0] dot_radius;
    logic             inside_res;

    fvt_plane_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    // fields narrower or wider than the bus are zero-extended, then taken
    // as two's complement at coordinate width
    always_comb begin
        item_next.cmd    = cmd_t'(s_tuser);
        item_next.lo_x   = coord_t'(s_tdata[0  +: FIELD_W]);
        item_next.lo_y   = coord_t'(s_tdata[16 +: FIELD_W]);
        item_next.lo_z   = coord_t'(s_tdata[32 +: FIELD_W]);
        item_next.hi_x   = coord_t'(s_tdata[48 +: FIELD_W]);
        item_next.hi_y   = coord_t'(s_tdata[64 +: FIELD_W]);
        item_next.hi_z   = coord_t'(s_tdata[80 +: FIELD_W]);
        item_next.radius = s_tdata[96 +: RAD_W];
    end

    assign in_ready   = !valid_reg || dot_in_ready;
    assign s_tready   = in_ready;
    assign valid_next = in_ready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_tvalid) begin
            item_reg <= item_next;
        end
    end

    fvt_dot_stage u_dot (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (valid_reg),
        .in_ready   (dot_in_ready),
        .item       (item_reg),
        .planes     (planes),
        .out_hs_fwd (dot_hs),
        .out_ready  (dec_in_ready),
        .prod       (prod),
        .cmd        (dot_cmd),
        .radius     (dot_radius)
    );

    fvt_decide u_dec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (dot_hs.valid),
        .in_ready   (dec_in_ready),
        .prod       (prod),
        .cmd        (dot_cmd),
        .radius     (dot_radius),
        .planes     (planes),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .inside_res (inside_res)
    );

    assign m_tdata = {7'b0000000, inside_res};

    // an empty input register always takes a beat
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg |-> s_tready)
        else $error("input register empty but s_tready low");

    // a primitive with no test never reports inside
    a_none_fails: assert property (@(posedge aclk) disable iff (!aresetn)
        (dot_hs.valid && dec_in_ready && (dot_cmd == CMD_NONE)) |=> !m_tdata[0])
        else $error("unused kind reported inside");

    // a product beat blocked by the result stage holds its kind
    a_dot_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (dot_hs.valid && !dec_in_ready) |=> (dot_hs.valid && $stable(dot_cmd)))
        else $error("product stage beat lost under stall");

    // a beat taken from the input register reaches the product stage next
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && dot_in_ready) |=> dot_hs.valid)
        else $error("beat dropped between input and product stage");

endmodule

FILE: tb/frustum_visibility_test_tb.sv
// ----------------------------------------------------------------------------
// frustum_visibility_test_tb
// Streams points, boxes and spheres through the visibility tester under
// several plane sets (reset zeros, a plain box frustum, axis and tilted
// frusta, extreme and noise planes) with random gaps on both sides, and
// checks every result beat against table values or a local fixed-point predictor.
// ----------------------------------------------------------------------------
module frustum_visibility_test_tb;

    import fvt_pkg::*;

    typedef enum logic [CFG_IDX_W-1:0] {
        PLANE_LEFT, PLANE_RIGHT, PLANE_TOP, PLANE_BOTTOM, PLANE_NEAR, PLANE_FAR,
        PLANE_SPARE_A, PLANE_SPARE_B
    } plane_idx_t;

    typedef enum int {
        PL_AXIS, PL_TILTED, PL_EXTREME, PL_NOISE, PL_ZERO
    } plane_style_t;

    typedef struct {
        item_t it;
        bit    inside_res;
    } verdict_t;

    typedef struct {
        item_t it;
        bit    typed;
        bit    inside_res;
    } dir_row_t;

    localparam int DIR_ROWS        = 24;
    localparam int RESET_ROWS      = 9;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 250;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PLANE_W-1:0]   cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [111:0]         s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;

    plane_t      frustum_planes [NUM_PLANES];
    verdict_t    verdict_q [$];
    int          mismatches  = 0;
    int          results_got = 0;
    int          send_calm   = 0;
    int          recv_calm   = 0;

    frustum_visibility_test u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    // signed distance n.v + d in q.14, exact in 64 bits
    function automatic bit inside_frustum(input item_t it);
        longint lo [3];
        longint hi [3];
        longint v [3];
        longint n [3];
        longint d, dist_sum, rad_q;
        int     i, a;
        bit     ok;
        lo[0] = it.lo_x;  lo[1] = it.lo_y;  lo[2] = it.lo_z;
        hi[0] = it.hi_x;  hi[1] = it.hi_y;  hi[2] = it.hi_z;
        rad_q = longint'(it.radius) <<< FRAC_BITS;
        if (it.cmd == CMD_NONE)
            return 1'b0;
        ok = 1'b1;
        for (i = 0; i < NUM_PLANES; i++) begin
            d = $signed(frustum_planes[i][48 +: 16]);
            dist_sum = d <<< FRAC_BITS;
            for (a = 0; a < 3; a++) begin
                n[a] = $signed(frustum_planes[i][16*a +: 16]);
                if (it.cmd == CMD_BOX)
                    v[a] = (n[a] <= 0) ? lo[a] : hi[a];
                else
                    v[a] = lo[a];
                dist_sum += n[a] * v[a];
            end
            case (it.cmd)
                CMD_POINT:  if (dist_sum <= 0) ok = 1'b0;
                CMD_BOX:    if (dist_sum < 0) ok = 1'b0;
                CMD_SPHERE: if (dist_sum <= -rad_q) ok = 1'b0;
                default:    ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

    function automatic plane_t pack_plane(input int nx, input int ny, input int nz,
                                          input int d);
        return {d[15:0], nz[15:0], ny[15:0], nx[15:0]};
    endfunction

    function automatic plane_t random_plane(input plane_style_t style, input int slot);
        int     n [3];
        int     axis, sgn, a, f;
        plane_t p;
        axis = slot / 2;
        sgn  = (slot % 2 == 0) ? 1 : -1;
        case (style)
            PL_EXTREME: begin
                for (f = 0; f < 4; f++) begin
                    case ($urandom_range(0, 3))
                        0: p[16*f +: 16] = 16'h8000;
                        1: p[16*f +: 16] = 16'h7fff;
                        2: p[16*f +: 16] = 16'h0000;
                        default: p[16*f +: 16] = 16'hffff;
                    endcase
                end
                return p;
            end
            PL_NOISE: return {$urandom, $urandom};
            PL_ZERO:  return '0;
            default: begin
                for (a = 0; a < 3; a++)
                    n[a] = (style == PL_TILTED) ? int'($urandom_range(0, 8192)) - 4096 : 0;
                n[axis] = sgn * int'($urandom_range(8192, 32767));
                return pack_plane(n[0], n[1], n[2], int'($urandom_range(0, 3000)) - 300);
            end
        endcase
    endfunction

    function automatic coord_t rand_coord(input bit wide);
        return wide ? coord_t'($urandom) : coord_t'(int'($urandom_range(0, 8000)) - 4000);
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    sel, h0, h1, h2;
        bit    wide;
        sel  = $urandom_range(0, 15);
        it.cmd = (sel < 5) ? CMD_POINT : (sel < 10) ? CMD_BOX :
                 (sel < 15) ? CMD_SPHERE : CMD_NONE;
        wide = ($urandom_range(0, 3) == 0);
        it.lo_x = rand_coord(wide);
        it.lo_y = rand_coord(wide);
        it.lo_z = rand_coord(wide);
        if ($urandom_range(0, 7) == 0) begin
            // unordered corners, inverted boxes among them
            it.hi_x = coord_t'($urandom);
            it.hi_y = coord_t'($urandom);
            it.hi_z = coord_t'($urandom);
        end else begin
            h0 = int'(it.lo_x) + int'($urandom_range(0, 1500));
            h1 = int'(it.lo_y) + int'($urandom_range(0, 1500));
            h2 = int'(it.lo_z) + int'($urandom_range(0, 1500));
            it.hi_x = coord_t'((h0 > 32767) ? 32767 : h0);
            it.hi_y = coord_t'((h1 > 32767) ? 32767 : h1);
            it.hi_z = coord_t'((h2 > 32767) ? 32767 : h2);
        end
        case ($urandom_range(0, 7))
            0:       it.radius = '0;
            1:       it.radius = RAD_W'($urandom);
            default: it.radius = RAD_W'($urandom_range(0, 1500));
        endcase
        return it;
    endfunction

    function automatic dir_row_t mk_row(input cmd_t cmd, input int lx, input int ly,
                                        input int lz, input int hx, input int hy,
                                        input int hz, input int r, input bit typed,
                                        input bit inside_res);
        dir_row_t row;
        row.it.cmd     = cmd;
        row.it.lo_x    = coord_t'(lx);
        row.it.lo_y    = coord_t'(ly);
        row.it.lo_z    = coord_t'(lz);
        row.it.hi_x    = coord_t'(hx);
        row.it.hi_y    = coord_t'(hy);
        row.it.hi_z    = coord_t'(hz);
        row.it.radius  = RAD_W'(r);
        row.typed      = typed;
        row.inside_res = inside_res;
        return row;
    endfunction

    // wait in cycles before the next beat, with runs of back-to-back beats
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
            calm = $urandom_range(10, 60);
        return $urandom_range(0, 11);
    endfunction

    task automatic flag(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", what);
    endtask

    task automatic send_item(input item_t it, input bit inside_res);
        verdict_t vd;
        int       gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {1'b0, it.radius, it.hi_z, it.hi_y, it.hi_x, it.lo_z, it.lo_y, it.lo_x};
        do @(posedge aclk); while (!s_tready);
        vd.it         = it;
        vd.inside_res = inside_res;
        verdict_q.push_back(vd);
    endtask

    task automatic write_plane(input plane_idx_t idx, input plane_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (int'(idx) < NUM_PLANES)
            frustum_planes[int'(idx)] = val;
    endtask

    // indexes past the last plane get random data and must be dropped
    task automatic load_frustum(input plane_t set [NUM_PLANES]);
        int k;
        if ($urandom_range(0, 1) == 0)
            write_plane(PLANE_SPARE_A, {$urandom, $urandom});
        for (k = 0; k < NUM_PLANES; k++)
            write_plane(plane_idx_t'(k), set[k]);
        write_plane(PLANE_SPARE_B, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
    endtask

    // result side
    initial begin
        int       stall;
        verdict_t vd;
        @(posedge aresetn);
        forever begin
            stall = draw_wait(recv_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            results_got++;
            if (verdict_q.size() == 0) begin
                flag($sformatf("result %0d arrived with nothing pending: got %02h",
                               results_got, m_tdata));
            end else begin
                vd = verdict_q.pop_front();
                if (m_tdata !== {7'b0, vd.inside_res})
                    flag($sformatf("result %0d (cmd %0d): expected %02h, got %02h",
                                   results_got, vd.it.cmd, {7'b0, vd.inside_res}, m_tdata));
            end
        end
    end

    initial begin
        dir_row_t     dir_rows [DIR_ROWS];
        plane_t       set [NUM_PLANES];
        plane_style_t phase_style [NUM_PHASES];
        item_t        it;
        int           k, p, s;

        phase_style = '{PL_AXIS, PL_TILTED, PL_EXTREME, PL_AXIS,
                        PL_NOISE, PL_TILTED, PL_AXIS, PL_ZERO};
        for (k = 0; k < NUM_PLANES; k++)
            frustum_planes[k] = '0;

        dir_rows = '{
            // zero planes after reset: points fail, boxes pass, spheres need radius
            mk_row(CMD_POINT,  0, 0, 0, 0, 0, 0, 0, 1, 0),
            mk_row(CMD_POINT,  32767, -32768, 32767, 0, 0, 0, 32767, 1, 0),
            mk_row(CMD_BOX,    -32768, -32768, -32768, 32767, 32767, 32767, 0, 1, 1),
            mk_row(CMD_BOX,    32767, 32767, 32767, -32768, -32768, -32768, 0, 1, 1),
            mk_row(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0, 1, 0),
            mk_row(CMD_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767, 1, 1),
            mk_row(CMD_SPHERE, 5, -5, 5, 0, 0, 0, 1, 1, 1),
            mk_row(CMD_NONE,   0, 0, 0, 0, 0, 0, 0, 1, 0),
            mk_row(CMD_NONE,   32767, 32767, 32767, 32767, 32767, 32767, 32767, 1, 0),
            // box frustum: |x| < 1000, |y| < 1000, 0 < z < 2000
            mk_row(CMD_POINT,  0, 0, 500, 0, 0, 0, 0, 0, 0),
            mk_row(CMD_POINT,  -1000, 0, 500, 0, 0, 0, 0, 0, 0),
            mk_row(CMD_POINT,  999, 999, 1999, 0, 0, 0, 0, 0, 0),
            mk_row(CMD_POINT,  0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(CMD_BOX,    -2000, 0, 100, -1001, 10, 200, 0, 0, 0),
            mk_row(CMD_BOX,    -5000, -5000, -5000, 5000, 5000, 5000, 0, 0, 0),
            mk_row(CMD_BOX,    -3000, 0, 100, -1000, 0, 100, 0, 0, 0),
            mk_row(CMD_BOX,    500, 500, 500, -500, -500, -500, 0, 0, 0),
            mk_row(CMD_SPHERE, -1500, 0, 500, 0, 0, 0, 500, 0, 0),
            mk_row(CMD_SPHERE, -1500, 0, 500, 0, 0, 0, 501, 0, 0),
            mk_row(CMD_SPHERE, 32767, 32767, 32767, 0, 0, 0, 32767, 0, 0),
            mk_row(CMD_SPHERE, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0),
            mk_row(CMD_POINT,  -32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0),
            mk_row(CMD_NONE,   0, 0, 500, 0, 0, 500, 100, 0, 0),
            mk_row(CMD_BOX,    -32768, -32768, -32768, 32767, 32767, 32767, 32767, 0, 0)
        };

        set[PLANE_LEFT]   = pack_plane(16384, 0, 0, 1000);
        set[PLANE_RIGHT]  = pack_plane(-16384, 0, 0, 1000);
        set[PLANE_TOP]    = pack_plane(0, -16384, 0, 1000);
        set[PLANE_BOTTOM] = pack_plane(0, 16384, 0, 1000);
        set[PLANE_NEAR]   = pack_plane(0, 0, 16384, 0);
        set[PLANE_FAR]    = pack_plane(0, 0, -16384, 2000);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < DIR_ROWS; k++) begin
            if (k == RESET_ROWS) begin
                settle();
                load_frustum(set);
            end
            send_item(dir_rows[k].it,
                      dir_rows[k].typed ? dir_rows[k].inside_res
                                        : inside_frustum(dir_rows[k].it));
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            settle();
            for (s = 0; s < NUM_PLANES; s++)
                set[s] = random_plane(phase_style[p], s);
            load_frustum(set);
            repeat (ITEMS_PER_PHASE) begin
                it = random_item();
                send_item(it, inside_frustum(it));
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/fvt_pkg.sv
src/fvt_plane_regs.sv
src/fvt_dot_stage.sv
src/fvt_decide.sv
src/frustum_visibility_test.sv
tb/frustum_visibility_test_tb.sv
